FILE: design/chsp_pkg.sv
// ============================================================================
// Convex hull support point: shared package
// Widths, codes, types and fixed-point helpers used by the support point
// block and its sequencer and dot-product unit.
// ============================================================================
package chsp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 24;
  localparam int FIELD_W      = 24;
  localparam int SLOT_W       = 10;
  localparam int KIND_W       = 2;
  localparam int POSE_W       = 24;
  localparam int POSE_WORDS   = 12;
  localparam int POSE_AW      = $clog2(POSE_WORDS);
  localparam int POSE_T0      = 9;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VTX_W        = 3 * COORD_BITS;
  localparam int DIR_W        = POSE_W + COORD_BITS - 14;
  localparam int PROD_W       = DIR_W + COORD_BITS;
  localparam int SUM_W        = PROD_W + 2;
  localparam int OUT_W        = 26;
  localparam int APB_AW       = 2;
  localparam int APB_DW       = 32;
  localparam int FRAC_BITS    = 16;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] OUT_HI   = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] OUT_LO   = ~OUT_HI;

  typedef enum logic [KIND_W-1:0] {
    KIND_VTX   = 2'd0,
    KIND_POSE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_DIR,
    OP_SCAN,
    OP_WORLD
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR,
    ST_DIR_WAIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_WORLD_RD,
    ST_WORLD,
    ST_WORLD_WAIT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       lane;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic vtx_we;
    logic pose_we;
  } load_t;

  typedef logic [POSE_WORDS-1:0][POSE_W-1:0] pose_t;

  // Round half up to the Q.16 grid; the shift is arithmetic, so it floors.
  function automatic logic signed [SUM_W-1:0] round16(input logic signed [SUM_W-1:0] v);
    return (v + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v;
    if (s > OUT_HI) begin
      s = OUT_HI;
    end else if (s < OUT_LO) begin
      s = OUT_LO;
    end
    return s[OUT_W-1:0];
  endfunction

  // Column c of the rotation, i.e. row c of its transpose.
  function automatic logic [2:0][DIR_W-1:0] pose_col(input pose_t p, input logic [1:0] c);
    logic [2:0][POSE_W-1:0] w;
    logic [2:0][DIR_W-1:0]  r;
    case (c)
      2'd0:    w = {p[6], p[3], p[0]};
      2'd1:    w = {p[7], p[4], p[1]};
      default: w = {p[8], p[5], p[2]};
    endcase
    for (int k = 0; k < 3; k++) begin
      r[k] = DIR_W'($signed(w[k]));
    end
    return r;
  endfunction

  function automatic logic [2:0][DIR_W-1:0] pose_row(input pose_t p, input logic [1:0] c);
    logic [2:0][POSE_W-1:0] w;
    logic [2:0][DIR_W-1:0]  r;
    case (c)
      2'd0:    w = {p[2], p[1], p[0]};
      2'd1:    w = {p[5], p[4], p[3]};
      default: w = {p[8], p[7], p[6]};
    endcase
    for (int k = 0; k < 3; k++) begin
      r[k] = DIR_W'($signed(w[k]));
    end
    return r;
  endfunction

  // Translation of row c, placed on the Q.32 grid of the product sums.
  function automatic logic signed [SUM_W-1:0] pose_trans(input pose_t p, input logic [1:0] c);
    logic [POSE_W-1:0] w;
    case (c)
      2'd0:    w = p[POSE_T0];
      2'd1:    w = p[POSE_T0 + 1];
      default: w = p[POSE_T0 + 2];
    endcase
    return SUM_W'($signed(w)) <<< FRAC_BITS;
  endfunction

endpackage

FILE: design/convex_hull_support_point.sv
// ============================================================================
// Convex hull support point
// Stores up to 1024 hull vertices and a rigid pose, and answers support
// queries: the stored vertex with the greatest projection on a world
// direction, returned in world coordinates with its index. When the previous
// winner is still valid and lies within the count, it is read first as the
// seed. The vertex scan reads one vertex per cycle from the single read port
// of the vertex store into the shared three-lane dot-product unit. Counts
// above 1024 scan 1024 vertices. A query with no vertices strobes its word
// in the cycle after the start edge with valid_res_o low. Vertex and pose
// loads forget the remembered winner. busy is high while a query runs;
// done_o marks each result word for exactly one cycle and cannot be held
// off by the receiver.
// ============================================================================
module convex_hull_support_point import chsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [FIELD_W-1:0]   x_val_i,
  input  logic [FIELD_W-1:0]   y_val_i,
  input  logic [FIELD_W-1:0]   z_val_i,
  output logic                 done_o,
  output logic [OUT_W-1:0]     point_x_o,
  output logic [OUT_W-1:0]     point_y_o,
  output logic [OUT_W-1:0]     point_z_o,
  output logic [IDX_W-1:0]     winner_index_o,
  output logic                 valid_res_o
);

  localparam logic [APB_AW-1:0] ADDR_VERTEX_COUNT = '0;

  logic [CNT_W-1:0]  count_q;
  pose_t             pose_q;
  load_t             load;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VTX_W-1:0]  ram_rdata;
  logic              cfg_hit;

  assign cfg_hit = (paddr == ADDR_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DW'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pose_q  <= '0;
    end else begin
      if (psel && penable && pwrite && pready && cfg_hit) begin
        count_q <= pwdata[CNT_W-1:0];
      end
      if (load.pose_we) begin
        pose_q[slot_i[POSE_AW-1:0]] <= x_val_i[POSE_W-1:0];
      end
    end
  end

  chsp_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (load.vtx_we),
    .waddr_i (slot_i[IDX_W-1:0]),
    .wdata_i ({z_val_i[COORD_BITS-1:0], y_val_i[COORD_BITS-1:0], x_val_i[COORD_BITS-1:0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  chsp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .x_val_i        (x_val_i),
    .y_val_i        (y_val_i),
    .z_val_i        (z_val_i),
    .count_i        (count_q),
    .pose_i         (pose_q),
    .busy_o         (busy),
    .load_o         (load),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .done_o         (done_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .winner_index_o (winner_index_o),
    .valid_res_o    (valid_res_o)
  );

endmodule

FILE: design/chsp_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data, which holds
// while no read is requested.
// ============================================================================
module chsp_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/chsp_dot3.sv
// ============================================================================
// Shared three-lane dot-product unit
// Multiplies three operand pairs, registers the products, then registers
// their exact sum. A tag travels alongside so the sequencer can route it.
// ============================================================================
module chsp_dot3 import chsp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  tag_t                         tag_i,
  input  logic [2:0][DIR_W-1:0]        a_i,
  input  logic [2:0][COORD_BITS-1:0]   b_i,
  output logic                         valid_o,
  output tag_t                         tag_o,
  output logic signed [SUM_W-1:0]      sum_o
);

  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [PROD_W-1:0] prod_d [3];
  logic                     valid1_q;
  tag_t                     tag1_q;
  logic                     valid2_q;
  tag_t                     tag2_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  sum_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = $signed(a_i[k]) * $signed(b_i[k]);
    end
    sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
    tag1_q <= tag_i;
    sum_q  <= sum_d;
    tag2_q <= tag1_q;
  end

  assign valid_o = valid2_q;
  assign tag_o   = tag2_q;
  assign sum_o   = sum_q;

endmodule

FILE: design/chsp_core.sv
// ============================================================================
// Support point sequencer
// Steps a query through the direction transform, the seeded vertex scan and
// the world transform, all on the shared dot-product unit.
// ============================================================================
module chsp_core import chsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [SLOT_W-1:0]       slot_i,
  input  logic [FIELD_W-1:0]      x_val_i,
  input  logic [FIELD_W-1:0]      y_val_i,
  input  logic [FIELD_W-1:0]      z_val_i,
  input  logic [CNT_W-1:0]        count_i,
  input  pose_t                   pose_i,
  output logic                    busy_o,
  output load_t                   load_o,
  output logic                    ram_re_o,
  output logic [IDX_W-1:0]        ram_raddr_o,
  input  logic [VTX_W-1:0]        ram_rdata_i,
  output logic                    done_o,
  output logic [OUT_W-1:0]        point_x_o,
  output logic [OUT_W-1:0]        point_y_o,
  output logic [OUT_W-1:0]        point_z_o,
  output logic [IDX_W-1:0]        winner_index_o,
  output logic                    valid_res_o
);

  state_e                        state_q, state_d;
  logic [1:0]                    step_q, step_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic                          seed_q, seed_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic [2:0][COORD_BITS-1:0]    dir_q, dir_d;
  logic [2:0][DIR_W-1:0]         mdir_q, mdir_d;
  logic                          rd_pend_q, rd_pend_d;
  tag_t                          rd_tag_q, rd_tag_d;
  logic signed [SUM_W-1:0]       best_q, best_d;
  logic [IDX_W-1:0]              best_idx_q, best_idx_d;
  logic                          have_q, have_d;
  logic                          win_ok_q, win_ok_d;
  logic [IDX_W-1:0]              win_idx_q, win_idx_d;
  logic [2:0][OUT_W-1:0]         point_q, point_d;
  logic [IDX_W-1:0]              widx_q, widx_d;
  logic                          valid_res_q, valid_res_d;
  logic                          done_q, done_d;

  logic                          dot_valid;
  tag_t                          dot_tag;
  logic [2:0][DIR_W-1:0]         dot_a;
  logic [2:0][COORD_BITS-1:0]    dot_b;
  logic                          res_valid;
  tag_t                          res_tag;
  logic signed [SUM_W-1:0]       res_sum;

  kind_e                         kind;
  logic                          accept;
  logic [CNT_W-1:0]              n_eff;
  logic                          scan_last;
  logic                          dir_done;
  logic                          scan_done;
  logic                          world_done;
  logic signed [SUM_W-1:0]       rounded;

  assign kind      = kind_e'(kind_i);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign n_eff     = (count_i > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_i;
  assign scan_last = !seed_q && (CNT_W'(idx_q) == (n_q - CNT_W'(1)));
  assign dir_done   = res_valid && (res_tag.op == OP_DIR) && (res_tag.lane == 2'd2);
  assign scan_done  = res_valid && (res_tag.op == OP_SCAN) && res_tag.last;
  assign world_done = res_valid && (res_tag.op == OP_WORLD) && (res_tag.lane == 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (kind == KIND_QUERY) && (n_eff != '0)) begin
          state_d = ST_DIR;
        end
      end
      ST_DIR: begin
        if (step_q == 2'd2) begin
          state_d = ST_DIR_WAIT;
        end
      end
      ST_DIR_WAIT: begin
        if (dir_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        if (scan_done) begin
          state_d = ST_WORLD_RD;
        end
      end
      ST_WORLD_RD: begin
        state_d = ST_WORLD;
      end
      ST_WORLD: begin
        if (step_q == 2'd2) begin
          state_d = ST_WORLD_WAIT;
        end
      end
      ST_WORLD_WAIT: begin
        if (world_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    rd_pend_d   = 1'b0;
    rd_tag_d    = '{op: OP_SCAN, lane: 2'd0, last: 1'b0, idx: '0};
    dot_valid   = 1'b0;
    dot_tag     = '{op: OP_DIR, lane: step_q, last: 1'b0, idx: '0};
    dot_a       = '0;
    dot_b       = '0;
    load_o.vtx_we  = accept && (kind == KIND_VTX) && (CNT_W'(slot_i) < CNT_W'(MAX_VERTICES));
    load_o.pose_we = accept && (kind == KIND_POSE) && (slot_i < SLOT_W'(POSE_WORDS));

    unique case (state_q)
      ST_SCAN: begin
        ram_re_o  = 1'b1;
        rd_pend_d = 1'b1;
        if (seed_q) begin
          ram_raddr_o  = win_idx_q;
          rd_tag_d.idx = win_idx_q;
        end else begin
          ram_raddr_o   = idx_q;
          rd_tag_d.idx  = idx_q;
          rd_tag_d.last = scan_last;
        end
      end
      ST_WORLD_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = best_idx_q;
      end
      ST_DIR: begin
        dot_valid = 1'b1;
        dot_a     = pose_col(pose_i, step_q);
        dot_b     = dir_q;
      end
      ST_WORLD: begin
        dot_valid  = 1'b1;
        dot_tag.op = OP_WORLD;
        dot_a      = pose_row(pose_i, step_q);
        dot_b      = ram_rdata_i;
      end
      default: begin
      end
    endcase

    if (rd_pend_q) begin
      dot_valid = 1'b1;
      dot_tag   = rd_tag_q;
      dot_a     = mdir_q;
      dot_b     = ram_rdata_i;
    end
  end

  always_comb begin
    step_d      = 2'd0;
    idx_d       = idx_q;
    seed_d      = seed_q;
    n_d         = n_q;
    dir_d       = dir_q;
    mdir_d      = mdir_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    have_d      = have_q;
    win_ok_d    = win_ok_q;
    win_idx_d   = win_idx_q;
    point_d     = point_q;
    widx_d      = widx_q;
    valid_res_d = valid_res_q;
    done_d      = 1'b0;
    rounded     = '0;

    if ((state_q == ST_DIR) || (state_q == ST_WORLD)) begin
      step_d = (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
    end
    if (state_q == ST_SCAN) begin
      seed_d = 1'b0;
      if (!seed_q) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end

    if (load_o.vtx_we || load_o.pose_we) begin
      win_ok_d = 1'b0;
    end
    if (accept && (kind == KIND_QUERY)) begin
      dir_d  = {z_val_i[COORD_BITS-1:0], y_val_i[COORD_BITS-1:0], x_val_i[COORD_BITS-1:0]};
      n_d    = n_eff;
      seed_d = win_ok_q && (CNT_W'(win_idx_q) < n_eff);
      idx_d  = '0;
      have_d = 1'b0;
      if (n_eff == '0) begin
        point_d     = '0;
        widx_d      = '0;
        valid_res_d = 1'b0;
        done_d      = 1'b1;
      end
    end

    if (res_valid) begin
      case (res_tag.op)
        OP_DIR: begin
          rounded = round16(res_sum);
          mdir_d[res_tag.lane] = rounded[DIR_W-1:0];
        end
        OP_SCAN: begin
          if (!have_q || (res_sum > best_q)) begin
            best_d     = res_sum;
            best_idx_d = res_tag.idx;
            have_d     = 1'b1;
          end
        end
        OP_WORLD: begin
          rounded = round16(res_sum + pose_trans(pose_i, res_tag.lane));
          point_d[res_tag.lane] = sat_out(rounded);
          if (res_tag.lane == 2'd2) begin
            widx_d      = best_idx_q;
            valid_res_d = 1'b1;
            done_d      = 1'b1;
            win_ok_d    = 1'b1;
            win_idx_d   = best_idx_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= 2'd0;
      idx_q     <= '0;
      seed_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      have_q    <= 1'b0;
      win_ok_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      idx_q     <= idx_d;
      seed_q    <= seed_d;
      rd_pend_q <= rd_pend_d;
      have_q    <= have_d;
      win_ok_q  <= win_ok_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    dir_q       <= dir_d;
    mdir_q      <= mdir_d;
    rd_tag_q    <= rd_tag_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    win_idx_q   <= win_idx_d;
    point_q     <= point_d;
    widx_q      <= widx_d;
    valid_res_q <= valid_res_d;
  end

  chsp_dot3 u_dot3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dot_valid),
    .tag_i   (dot_tag),
    .a_i     (dot_a),
    .b_i     (dot_b),
    .valid_o (res_valid),
    .tag_o   (res_tag),
    .sum_o   (res_sum)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign point_x_o      = point_q[0];
  assign point_y_o      = point_q[1];
  assign point_z_o      = point_q[2];
  assign winner_index_o = widx_q;
  assign valid_res_o    = valid_res_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("Result word issued while a query is still in progress.");

  a_dir_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res_tag.op == OP_DIR)) |-> ((state_q == ST_DIR) || (state_q == ST_DIR_WAIT)))
    else $error("Direction product returned outside the direction phase.");

  a_read_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ((state_q == ST_SCAN) || (state_q == ST_SCAN_WAIT)))
    else $error("Scan read in flight outside the scan phase.");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && !seed_q) |-> (CNT_W'(idx_q) < n_q))
    else $error("Scan index ran past the vertex count.");

  a_winner_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && valid_res_q) |-> (CNT_W'(widx_q) < n_q))
    else $error("Winning index lies outside the scanned vertices.");

endmodule
